@@ design/stc_pkg.sv @@
// Shared constants, codes and types for the scope trigger capture block.
`timescale 1ns / 1ps
package stc_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int HALF     = DEPTH / 2;
    localparam int SAMPLE_W = 12;
    localparam int LINES_W  = 3;
    localparam int POS_W    = 10;
    localparam int ENTRY_W  = SAMPLE_W + LINES_W;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 12'd2048;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_START  = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        EDGE_RISE = 2'd0,
        EDGE_FALL = 2'd1,
        EDGE_BOTH = 2'd2
    } edge_mode_t;

    localparam logic [1:0] SRC_ANALOG = 2'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_SOURCE = 2'd2;

    typedef struct packed {
        logic              capturing;
        logic              is_triggered;
        logic              done_res;
        logic [POS_W-1:0]  trigger_position;
        logic [POS_W-1:0]  next_position;
    } status_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [ADDR_W-1:0]  waddr;
        logic [ADDR_W-1:0]  raddr;
        logic [ENTRY_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level_code;
        logic [1:0]          edge_mode;
        logic [1:0]          trigger_source;
    } cfg_t;

endpackage

@@ design/stc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/stc_ctrl.sv @@
// Acquisition state, trigger detection and store access requests.
`timescale 1ns / 1ps
module stc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  stc_pkg::action_t             action,
    input  logic [stc_pkg::SAMPLE_W-1:0] analog_sample,
    input  logic [stc_pkg::LINES_W-1:0]  digital_lines,
    input  logic [stc_pkg::POS_W-1:0]    read_address,
    input  stc_pkg::cfg_t                cfg,
    output stc_pkg::status_t             status_next,
    output stc_pkg::ram_req_t            ram_req
);
    import stc_pkg::*;

    logic [ADDR_W-1:0]  write_index_reg, write_index_next;
    logic [ADDR_W-1:0]  trig_index_reg, trig_index_next;
    logic [ADDR_W-1:0]  post_count_reg, post_count_next;
    logic               trig_seen_reg, trig_seen_next;
    logic               wrapped_reg, wrapped_next;
    logic               running_reg, running_next;
    logic               finished_reg, finished_next;
    logic               watch_fall_reg, watch_fall_next;
    logic [LINES_W-1:0] prev_lines_reg, prev_lines_next;

    logic want_rise, want_fall;
    logic win_rise, win_fall;
    logic line_was, line_now;
    logic hit;

    always_comb
    begin
        want_rise = (cfg.edge_mode != EDGE_FALL);
        want_fall = (cfg.edge_mode != EDGE_RISE);
        win_rise  = !watch_fall_reg && (analog_sample > cfg.level_code);
        win_fall  = watch_fall_reg && (analog_sample < cfg.level_code);
        line_was  = prev_lines_reg[2'(cfg.trigger_source - 2'd1)];
        line_now  = digital_lines[2'(cfg.trigger_source - 2'd1)];
        if (cfg.trigger_source == SRC_ANALOG)
        begin
            hit = (win_rise && want_rise) || (win_fall && want_fall);
        end
        else
        begin
            hit = (!line_was && line_now && want_rise) || (line_was && !line_now && want_fall);
        end

        write_index_next = write_index_reg;
        trig_index_next  = trig_index_reg;
        post_count_next  = post_count_reg;
        trig_seen_next   = trig_seen_reg;
        wrapped_next     = wrapped_reg;
        running_next     = running_reg;
        finished_next    = finished_reg;
        watch_fall_next  = watch_fall_reg;
        prev_lines_next  = prev_lines_reg;

        ram_req.we    = 1'b0;
        ram_req.re    = 1'b0;
        ram_req.waddr = write_index_reg;
        ram_req.raddr = ADDR_W'(read_address);
        ram_req.wdata = {digital_lines, analog_sample};

        if (accept)
        begin
            case (action)
                ACT_START:
                begin
                    running_next     = 1'b1;
                    finished_next    = 1'b0;
                    trig_seen_next   = 1'b0;
                    wrapped_next     = 1'b0;
                    write_index_next = '0;
                    post_count_next  = '0;
                    watch_fall_next  = analog_sample > cfg.level_code;
                    prev_lines_next  = digital_lines;
                end
                ACT_SAMPLE:
                begin
                    if (running_reg)
                    begin
                        if (win_rise)
                        begin
                            watch_fall_next = 1'b1;
                        end
                        else if (win_fall)
                        begin
                            watch_fall_next = 1'b0;
                        end
                        prev_lines_next = digital_lines;
                        // Arm only once the pre-trigger half is filled.
                        if (hit && !trig_seen_reg
                            && (wrapped_reg || write_index_reg[ADDR_W-1]))
                        begin
                            trig_index_next = write_index_reg;
                            trig_seen_next  = 1'b1;
                        end
                        ram_req.we = 1'b1;
                        if (write_index_reg == ADDR_W'(DEPTH - 1))
                        begin
                            write_index_next = '0;
                            wrapped_next     = 1'b1;
                        end
                        else
                        begin
                            write_index_next = write_index_reg + 1'b1;
                        end
                        if (trig_seen_next)
                        begin
                            post_count_next = post_count_reg + 1'b1;
                            if (post_count_next == ADDR_W'(HALF))
                            begin
                                running_next  = 1'b0;
                                finished_next = 1'b1;
                            end
                        end
                    end
                end
                ACT_STOP:
                begin
                    running_next = 1'b0;
                end
                ACT_READ:
                begin
                    ram_req.re = 1'b1;
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end

        status_next.capturing        = running_next;
        status_next.is_triggered     = trig_seen_next;
        status_next.done_res         = finished_next;
        status_next.trigger_position = POS_W'(trig_index_next);
        status_next.next_position    = POS_W'(write_index_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            trig_index_reg  <= '0;
            post_count_reg  <= '0;
            trig_seen_reg   <= 1'b0;
            wrapped_reg     <= 1'b0;
            running_reg     <= 1'b0;
            finished_reg    <= 1'b0;
            watch_fall_reg  <= 1'b0;
            prev_lines_reg  <= '0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            trig_index_reg  <= trig_index_next;
            post_count_reg  <= post_count_next;
            trig_seen_reg   <= trig_seen_next;
            wrapped_reg     <= wrapped_next;
            running_reg     <= running_next;
            finished_reg    <= finished_next;
            watch_fall_reg  <= watch_fall_next;
            prev_lines_reg  <= prev_lines_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A finished capture is never still running.
    a_done_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !running_reg)
        else $error("finished capture still running");

    // Post-trigger samples are only counted after a trigger.
    a_post_needs_trig: assert property (@(posedge clk) disable iff (!rst_n)
        (post_count_reg != '0) |-> trig_seen_reg)
        else $error("post-trigger count without trigger");

    // The store is never written outside a running capture.
    a_write_when_running: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> running_reg)
        else $error("store written while idle");
`endif

endmodule

@@ design/scope_trigger_capture.sv @@
// Top level of the scope trigger capture block: ports, registers, store and output stage.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+------------------------------------------
//  s_axis    | in  | tvalid / tready        | tuser: action; tdata: sample, lines, addr
//  m_axis    | out | tvalid / tready        | tdata: status flags, positions, read data
//  cfg       | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat is accepted per cycle while m_axis does not stall; each beat gives one result beat,
// through the registered read of the sample store and then the output register.
// The store is a single 1024 x 15 RAM, written by sample beats and read by read beats.
// Reset clears the acquisition state; the store contents are not cleared.
// A stall on m_axis holds the output register and the stage behind it, then stalls s_axis.
`timescale 1ns / 1ps
module scope_trigger_capture (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] analog_sample, [14:12] digital_lines, [24:15] read_address, rest zero
    input  logic [stc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] capturing, [1] is_triggered, [2] done_res, [12:3] trigger_position,
    // [22:13] next_position, [34:23] read_analog, [37:35] read_digital, rest zero
    output logic [stc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stc_pkg::SAMPLE_W-1:0]        cfg_data
);
    import stc_pkg::*;

    cfg_t     cfg_reg;
    status_t  status_next;
    ram_req_t ram_req;

    logic               accept;
    logic               out_free;
    logic [ENTRY_W-1:0] ram_rdata;

    logic    s1_valid_reg;
    status_t s1_stat_reg;
    logic    s1_read_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [SAMPLE_W-1:0]     rd_analog;
    logic [LINES_W-1:0]      rd_digital;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_code     <= LEVEL_RESET;
            cfg_reg.edge_mode      <= EDGE_RISE;
            cfg_reg.trigger_source <= SRC_ANALOG;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEVEL_CODE:     cfg_reg.level_code     <= cfg_data;
                CFG_EDGE_MODE:      cfg_reg.edge_mode      <= cfg_data[1:0];
                CFG_TRIGGER_SOURCE: cfg_reg.trigger_source <= cfg_data[1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    stc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .action        (action_t'(s_axis_tuser)),
        .analog_sample (s_axis_tdata[11:0]),
        .digital_lines (s_axis_tdata[14:12]),
        .read_address  (s_axis_tdata[24:15]),
        .cfg           (cfg_reg),
        .status_next   (status_next),
        .ram_req       (ram_req)
    );

    stc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (s1_read_reg)
        begin
            rd_analog  = ram_rdata[SAMPLE_W-1:0];
            rd_digital = ram_rdata[ENTRY_W-1:SAMPLE_W];
        end
        else
        begin
            rd_analog  = '0;
            rd_digital = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= accept;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_stat_reg <= status_next;
            s1_read_reg <= (action_t'(s_axis_tuser) == ACT_READ);
        end
        if (out_free && s1_valid_reg)
        begin
            out_data_reg <= {2'b00, rd_digital, rd_analog,
                             s1_stat_reg.next_position, s1_stat_reg.trigger_position,
                             s1_stat_reg.done_res, s1_stat_reg.is_triggered,
                             s1_stat_reg.capturing};
        end
    end

`ifndef NO_ASSERTIONS
    // While the read stage waits on the output register, the store read data must hold.
    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> $stable(ram_rdata))
        else $error("store read data lost while stalled");

    // No store access is issued without an accepted beat.
    a_ram_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we || ram_req.re) |-> accept)
        else $error("store access without accepted beat");

    // An accepted beat always reaches the read stage on the next cycle.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost");
`endif

endmodule
